>>> hw/rtl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// Glyph bitmap edit engine package
// Shared constants, command codes and controller types.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int MaxColsDef = 32;
  localparam int MaxRowsDef = 32;

  localparam logic [5:0] WidthRst  = 6'd8;
  localparam logic [5:0] HeightRst = 6'd16;

  localparam logic [7:0] MsbPixel = 8'h80;
  localparam logic [7:0] LsbPixel = 8'h01;

  typedef enum logic [3:0] {
    CMD_TOGGLE  = 4'd0,
    CMD_SET     = 4'd1,
    CMD_CLEAR   = 4'd2,
    CMD_INVERT  = 4'd3,
    CMD_MIRROR  = 4'd4,
    CMD_DELCOL  = 4'd5,
    CMD_INSCOL  = 4'd6,
    CMD_DELROW  = 4'd7,
    CMD_INSROW  = 4'd8,
    CMD_WRBYTE  = 4'd9,
    CMD_RDBYTE  = 4'd10,
    CMD_SNAP    = 4'd11,
    CMD_RESTORE = 4'd12
  } cmd_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

>>> hw/rtl/gbe_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph bitmap edit engine controller
// Sequences one command: load, one row step a cycle, then result hold.
// ----------------------------------------------------------------------------
module gbe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output gbe_pkg::ctrl_t  ctrl,
  input  gbe_pkg::stat_t  stat
);

  gbe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    ctrl        = '0;
    case (state_r)
      gbe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.start = 1'b1;
          state_nxt  = gbe_pkg::ST_RUN;
        end
      end
      gbe_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        if (stat.last) begin
          state_nxt = gbe_pkg::ST_DONE;
        end
      end
      gbe_pkg::ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = gbe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbe_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/gbe_dp.sv
// ----------------------------------------------------------------------------
// Glyph bitmap edit engine datapath
// Grid and backup rows with a row walker that edits one row per cycle.
// ----------------------------------------------------------------------------
module gbe_dp #(
  parameter int MAX_COLS = gbe_pkg::MaxColsDef,
  parameter int MAX_ROWS = gbe_pkg::MaxRowsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [0:0]     cfg_index,
  input  logic [5:0]     cfg_data,
  input  logic [3:0]     cmd,
  input  logic [4:0]     col_index,
  input  logic [4:0]     row_index,
  input  logic [1:0]     byte_slot,
  input  logic [7:0]     byte_in,
  input  gbe_pkg::ctrl_t ctrl,
  output gbe_pkg::stat_t stat,
  output logic [7:0]     byte_out,
  output logic           index_error
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int MW = $clog2(MAX_COLS + 1);

  logic [MAX_COLS-1:0] pix_r [MAX_ROWS];
  logic [MAX_COLS-1:0] bak_r [MAX_ROWS];
  logic [5:0] wreg_r, hreg_r;
  logic [3:0] cmd_r;
  logic [4:0] col_r, row_r;
  logic [1:0] slot_r;
  logic [7:0] bin_r;
  logic [RW-1:0] i_r;
  logic [7:0] bout_r, bout_nxt;
  logic err_r, err_nxt;

  logic [MW-1:0] w;
  logic [NW-1:0] h;
  logic [MAX_COLS-1:0] m, lo, v, vn, hi, rev, pm, wrmask, wrbits;
  logic [RW-1:0] hm1, src_i;
  logic col_ok, row_ok, slot_ok, err_c, do_row, do_bak;
  logic [6:0] wp7;
  logic last_ins;

  always_comb begin
    if (wreg_r == 6'd0) w = MW'(1);
    else if ({26'd0, wreg_r} > 32'(MAX_COLS)) w = MW'(MAX_COLS);
    else w = MW'(wreg_r);
    if (hreg_r == 6'd0) h = NW'(1);
    else if ({26'd0, hreg_r} > 32'(MAX_ROWS)) h = NW'(MAX_ROWS);
    else h = NW'(hreg_r);
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      m[c]  = (32'(c) < 32'(w));
      lo[c] = (32'(c) < 32'(col_r));
    end
  end

  assign hm1     = RW'(h - NW'(1));
  assign wp7     = 7'(w) + 7'd7;
  assign col_ok  = 32'(col_r) < 32'(w);
  assign row_ok  = 32'(row_r) < 32'(h);
  assign slot_ok = {2'd0, slot_r} < wp7[6:3];

  always_comb begin
    case (cmd_r)
      gbe_pkg::CMD_TOGGLE, gbe_pkg::CMD_SET, gbe_pkg::CMD_CLEAR:
        err_c = !col_ok || !row_ok;
      gbe_pkg::CMD_DELCOL, gbe_pkg::CMD_INSCOL: err_c = !col_ok;
      gbe_pkg::CMD_DELROW, gbe_pkg::CMD_INSROW: err_c = !row_ok;
      gbe_pkg::CMD_WRBYTE, gbe_pkg::CMD_RDBYTE: err_c = !row_ok || !slot_ok;
      default: err_c = 1'b0;
    endcase
  end

  // Insert row walks from the last active row down to row zero, so its end test is on row zero.
  assign last_ins = (i_r == '0);

  assign stat.last = (cmd_r == gbe_pkg::CMD_INSROW) ? last_ins : (i_r == hm1);

  always_comb begin
    src_i = i_r;
    if (cmd_r == gbe_pkg::CMD_DELROW) src_i = (i_r == hm1) ? i_r : i_r + RW'(1);
    if (cmd_r == gbe_pkg::CMD_INSROW) src_i = (i_r == '0) ? i_r : i_r - RW'(1);
  end

  assign v  = pix_r[i_r];
  assign pm = pix_r[src_i] & m;

  always_comb begin
    for (int k = 0; k < MAX_COLS; k++) begin
      rev[k] = 1'b0;
      for (int j = 0; j < MAX_COLS; j++) begin
        if (32'(j) < 32'(w) && 32'(k) == 32'(w) - 32'd1 - 32'(j)) rev[k] = v[j];
      end
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      wrmask[c] = 1'b0;
      wrbits[c] = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if (32'(c) == 32'(slot_r) * 8 + k && m[c]) begin
          wrmask[c] = 1'b1;
          wrbits[c] = bin_r[7-k];
        end
      end
    end
  end

  always_comb begin
    vn       = v;
    do_row   = 1'b0;
    do_bak   = 1'b0;
    bout_nxt = bout_r;
    hi       = '0;
    if (!err_c && 32'(i_r) < 32'(h)) begin
      case (cmd_r)
        gbe_pkg::CMD_TOGGLE: begin
          do_row = (i_r == RW'(row_r));
          vn = v ^ (MAX_COLS'(1) << col_r);
        end
        gbe_pkg::CMD_SET: begin
          do_row = (i_r == RW'(row_r));
          vn = v | (MAX_COLS'(1) << col_r);
        end
        gbe_pkg::CMD_CLEAR: begin
          do_row = (i_r == RW'(row_r));
          vn = v & ~(MAX_COLS'(1) << col_r);
        end
        gbe_pkg::CMD_INVERT: begin
          do_row = 1'b1;
          vn = v ^ m;
        end
        gbe_pkg::CMD_MIRROR: begin
          do_row = 1'b1;
          vn = (v & ~m) | rev;
        end
        gbe_pkg::CMD_DELCOL: begin
          do_row = 1'b1;
          hi = ((v & m) >> 1) & ~lo;
          vn = (v & ~m) | (v & lo) | hi;
        end
        gbe_pkg::CMD_INSCOL: begin
          do_row = 1'b1;
          hi = ((v & m & ~lo) << 1) & m;
          vn = (v & ~m) | (v & lo) | hi;
        end
        gbe_pkg::CMD_DELROW: begin
          do_row = (32'(i_r) >= 32'(row_r));
          vn = (i_r == hm1) ? (v & ~m) : ((v & ~m) | pm);
        end
        gbe_pkg::CMD_INSROW: begin
          do_row = (32'(i_r) >= 32'(row_r));
          vn = (32'(i_r) == 32'(row_r)) ? (v & ~m) : ((v & ~m) | pm);
        end
        gbe_pkg::CMD_WRBYTE: begin
          do_row = (i_r == RW'(row_r));
          vn = (v & ~wrmask) | wrbits;
        end
        gbe_pkg::CMD_RDBYTE: begin
          if (i_r == RW'(row_r)) begin
            for (int k = 0; k < 8; k++) begin
              bout_nxt[7-k] = 1'b0;
              for (int c = 0; c < MAX_COLS; c++) begin
                if (32'(c) == 32'(slot_r) * 8 + k && m[c]) bout_nxt[7-k] = v[c];
              end
            end
          end
        end
        gbe_pkg::CMD_SNAP: do_bak = 1'b1;
        gbe_pkg::CMD_RESTORE: begin
          do_row = 1'b1;
          vn = (v & ~m) | (bak_r[i_r] & m);
        end
        default: ;
      endcase
    end
    err_nxt = err_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wreg_r <= gbe_pkg::WidthRst;
      hreg_r <= gbe_pkg::HeightRst;
      for (int r = 0; r < MAX_ROWS; r++) begin
        pix_r[r] <= '0;
        bak_r[r] <= '0;
      end
      i_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == gbe_pkg::CFG_WIDTH) wreg_r <= cfg_data;
        if (cfg_index == gbe_pkg::CFG_HEIGHT) hreg_r <= cfg_data;
      end
      if (ctrl.start) begin
        i_r <= (cmd == gbe_pkg::CMD_INSROW) ? hm1 : '0;
      end else if (ctrl.step) begin
        if (do_row) pix_r[i_r] <= vn;
        if (do_bak) bak_r[i_r] <= (bak_r[i_r] & ~m) | (v & m);
        if (cmd_r == gbe_pkg::CMD_INSROW) i_r <= i_r - RW'(1);
        else i_r <= i_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cmd_r  <= cmd;
      col_r  <= col_index;
      row_r  <= row_index;
      slot_r <= byte_slot;
      bin_r  <= byte_in;
      bout_r <= '0;
    end else if (ctrl.step) begin
      bout_r <= bout_nxt;
      err_r  <= err_nxt;
    end
  end

  assign byte_out    = bout_r;
  assign index_error = err_r;

endmodule

>>> hw/rtl/glyph_bitmap_edit_engine.sv
// ----------------------------------------------------------------------------
// A command walks every active row of the grid before its result is offered.
// A new command is taken only after the previous result has been transferred.
// Reset: grid and backup clear, width 8, height 16.
// ----------------------------------------------------------------------------
// Glyph bitmap edit engine
// Edits a one-bit glyph grid with backup copy under stream commands.
// ----------------------------------------------------------------------------
module glyph_bitmap_edit_engine #(
  parameter int MAX_COLS = gbe_pkg::MaxColsDef,
  parameter int MAX_ROWS = gbe_pkg::MaxRowsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[3:0], col_index[8:4], row_index[13:9], byte_slot[15:14], byte_in[23:16]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // byte_out[7:0], index_error[8], zero fill
  output logic [15:0] out_tdata
);

  gbe_pkg::ctrl_t ctrl;
  gbe_pkg::stat_t stat;
  logic [7:0] bout;
  logic       err;

  assign cfg_ready = 1'b1;

  gbe_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .ctrl, .stat
  );

  gbe_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .cmd(in_tdata[3:0]), .col_index(in_tdata[8:4]), .row_index(in_tdata[13:9]),
    .byte_slot(in_tdata[15:14]), .byte_in(in_tdata[23:16]),
    .ctrl, .stat, .byte_out(bout), .index_error(err)
  );

  assign out_tdata = {7'd0, err, bout};

endmodule
